/* rtl/mexp_pkg.sv */
// Package for the modular exponentiation core: widths, register indexes,
// reset values and the command/status types between controller and datapath.
// Depends on nothing; every other file refers to it by scoped names.
package mexp_pkg;

  localparam int unsigned EXP_BITS = 32;   // exponent bits scanned per word
  localparam int unsigned MSG_W    = 64;
  localparam int unsigned RES_W    = 32;
  localparam int unsigned EXP_W    = 32;
  localparam int unsigned MOD_W    = 33;
  localparam int unsigned CFG_W    = 33;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned EXP_USED = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
  localparam int unsigned IDX_W    = $clog2(EXP_USED + 1);
  localparam int unsigned CNT_W    = $clog2(MSG_W);
  localparam int unsigned SUM_W    = RES_W + 3;
  localparam int unsigned DIFF_W   = SUM_W + 1;

  localparam logic [EXP_W-1:0] EXP_RESET = EXP_W'(65537);
  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1);
  localparam logic [MOD_W-1:0] MOD_LIMIT = MOD_W'(1) << RES_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODULUS  = 1'b1;

  typedef struct packed {
    logic load_reduce;  // start reducing the message word
    logic load_mul;     // start acc * base
    logic load_sqr;     // start base * base
    logic step;         // one shift-add-reduce iteration
    logic wr_acc;       // acc takes the finishing iteration's value
    logic wr_base;      // base takes the finishing iteration's value
    logic init_exp;     // acc = 1, load exponent shifter
    logic shift_exp;    // move to the next exponent bit
  } dp_cmd_t;

  typedef struct packed {
    logic exp_bit;
  } dp_stat_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_ISSUE  = 6'b000100,
    S_MUL    = 6'b001000,
    S_SQR    = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

endpackage

/* rtl/mexp_dp.sv */
// Datapath of the modular exponentiation core: a bit-serial modular
// multiplier/reducer plus accumulator, base and exponent registers.
// Depends on mexp_pkg; driven by commands from mexp_ctrl.
module mexp_dp (
  input  logic                          clk_i,
  input  mexp_pkg::dp_cmd_t             cmd_i,
  input  logic [mexp_pkg::MSG_W-1:0]    message_word_i,
  input  logic [mexp_pkg::EXP_W-1:0]    exponent_i,
  input  logic [mexp_pkg::MOD_W-1:0]    modulus_i,
  output mexp_pkg::dp_stat_t            stat_o,
  output logic [mexp_pkg::RES_W-1:0]    acc_o
);

  logic [mexp_pkg::MSG_W-1:0]    a_q;
  logic [mexp_pkg::RES_W-1:0]    b_q;
  logic [mexp_pkg::RES_W-1:0]    r_q;
  logic [mexp_pkg::RES_W-1:0]    acc_q;
  logic [mexp_pkg::RES_W-1:0]    base_q;
  logic [mexp_pkg::EXP_USED-1:0] exp_q;
  logic                          reduce_q;

  logic [mexp_pkg::SUM_W-1:0]    addend;
  logic [mexp_pkg::SUM_W-1:0]    sum;
  logic [mexp_pkg::DIFF_W-1:0]   diff1;
  logic [mexp_pkg::DIFF_W-1:0]   diff2;
  logic [mexp_pkg::RES_W-1:0]    r_next;

  // The partial result stays below the modulus, so 2r + addend is below
  // three times the modulus and one of three candidates is the residue.
  always_comb begin
    addend = '0;
    if (reduce_q) begin
      addend = mexp_pkg::SUM_W'(a_q[mexp_pkg::MSG_W-1]);
    end else if (a_q[mexp_pkg::MSG_W-1]) begin
      addend = mexp_pkg::SUM_W'(b_q);
    end
    sum   = mexp_pkg::SUM_W'({r_q, 1'b0}) + addend;
    diff1 = {1'b0, sum} - mexp_pkg::DIFF_W'(modulus_i);
    diff2 = {1'b0, sum} - mexp_pkg::DIFF_W'({modulus_i, 1'b0});
    priority if (!diff2[mexp_pkg::DIFF_W-1]) begin
      r_next = diff2[mexp_pkg::RES_W-1:0];
    end else if (!diff1[mexp_pkg::DIFF_W-1]) begin
      r_next = diff1[mexp_pkg::RES_W-1:0];
    end else begin
      r_next = sum[mexp_pkg::RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.load_reduce) begin
      a_q      <= message_word_i;
      r_q      <= '0;
      reduce_q <= 1'b1;
    end else if (cmd_i.load_mul) begin
      a_q      <= {acc_q, {(mexp_pkg::MSG_W - mexp_pkg::RES_W){1'b0}}};
      b_q      <= base_q;
      r_q      <= '0;
      reduce_q <= 1'b0;
    end else if (cmd_i.load_sqr) begin
      a_q      <= {base_q, {(mexp_pkg::MSG_W - mexp_pkg::RES_W){1'b0}}};
      b_q      <= base_q;
      r_q      <= '0;
      reduce_q <= 1'b0;
    end else if (cmd_i.step) begin
      a_q <= a_q << 1;
      r_q <= r_next;
    end

    priority if (cmd_i.init_exp) begin
      acc_q <= mexp_pkg::RES_W'(1);
      exp_q <= exponent_i[mexp_pkg::EXP_USED-1:0];
    end else if (cmd_i.wr_acc) begin
      acc_q <= r_next;
    end else if (cmd_i.shift_exp) begin
      exp_q <= exp_q >> 1;
    end

    if (cmd_i.wr_base) begin
      base_q <= r_next;
    end
  end

  assign stat_o.exp_bit = exp_q[0];
  assign acc_o          = acc_q;

endmodule

/* rtl/mexp_ctrl.sv */
// Controller of the modular exponentiation core: sequences the reduction,
// the multiplies and squares per exponent bit, and the hand-off to output.
// Depends on mexp_pkg; commands mexp_dp.
module mexp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic               mod_bad_i,
  input  logic               mod_one_i,
  input  logic               out_free_i,
  input  mexp_pkg::dp_stat_t stat_i,
  output mexp_pkg::dp_cmd_t  cmd_o,
  output logic               idle_o,
  output logic               finish_o,
  output logic               res_zero_o,
  output logic               res_bad_o
);

  localparam logic [mexp_pkg::CNT_W-1:0] REDUCE_LAST = mexp_pkg::CNT_W'(mexp_pkg::MSG_W - 1);
  localparam logic [mexp_pkg::CNT_W-1:0] MUL_LAST    = mexp_pkg::CNT_W'(mexp_pkg::RES_W - 1);
  localparam logic [mexp_pkg::IDX_W-1:0] IDX_END     = mexp_pkg::IDX_W'(mexp_pkg::EXP_USED);

  mexp_pkg::state_e             state_q, state_d;
  logic [mexp_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [mexp_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic                         zero_q, zero_d;
  logic                         bad_q, bad_d;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    zero_d   = zero_q;
    bad_d    = bad_q;
    cmd_o    = '0;
    finish_o = 1'b0;
    unique case (state_q)
      mexp_pkg::S_IDLE: begin
        if (in_fire_i) begin
          bad_d  = mod_bad_i;
          zero_d = mod_bad_i | mod_one_i;
          if (mod_bad_i || mod_one_i) begin
            state_d = mexp_pkg::S_DONE;
          end else begin
            cmd_o.load_reduce = 1'b1;
            cnt_d             = '0;
            state_d           = mexp_pkg::S_REDUCE;
          end
        end
      end
      mexp_pkg::S_REDUCE: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + mexp_pkg::CNT_W'(1);
        if (cnt_q == REDUCE_LAST) begin
          cmd_o.wr_base  = 1'b1;
          cmd_o.init_exp = 1'b1;
          idx_d          = '0;
          state_d        = mexp_pkg::S_ISSUE;
        end
      end
      mexp_pkg::S_ISSUE: begin
        cnt_d = '0;
        if (idx_q == IDX_END) begin
          state_d = mexp_pkg::S_DONE;
        end else if (stat_i.exp_bit) begin
          cmd_o.load_mul = 1'b1;
          state_d        = mexp_pkg::S_MUL;
        end else begin
          cmd_o.load_sqr = 1'b1;
          state_d        = mexp_pkg::S_SQR;
        end
      end
      mexp_pkg::S_MUL: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + mexp_pkg::CNT_W'(1);
        if (cnt_q == MUL_LAST) begin
          cmd_o.wr_acc   = 1'b1;
          cmd_o.load_sqr = 1'b1;
          cnt_d          = '0;
          state_d        = mexp_pkg::S_SQR;
        end
      end
      mexp_pkg::S_SQR: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + mexp_pkg::CNT_W'(1);
        if (cnt_q == MUL_LAST) begin
          cmd_o.wr_base   = 1'b1;
          cmd_o.shift_exp = 1'b1;
          idx_d           = idx_q + mexp_pkg::IDX_W'(1);
          state_d         = mexp_pkg::S_ISSUE;
        end
      end
      mexp_pkg::S_DONE: begin
        if (out_free_i) begin
          finish_o = 1'b1;
          state_d  = mexp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mexp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mexp_pkg::S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      zero_q  <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      zero_q  <= zero_d;
      bad_q   <= bad_d;
    end
  end

  assign idle_o     = (state_q == mexp_pkg::S_IDLE);
  assign res_zero_o = zero_q;
  assign res_bad_o  = bad_q;

endmodule

/* rtl/modular_exponentiation_core.sv */
// Top level of the modular exponentiation core: configuration registers,
// input/output handshakes and the output register. Depends on mexp_pkg,
// mexp_ctrl and mexp_dp.
//
// Each accepted 64-bit message word produces one result word equal to
// message^exponent mod modulus, computed right to left by square and
// multiply. The exponent (register 0, reset 65537) and the modulus
// (register 1, reset 1) are written through the plain write port and must
// only change while the core is idle. A modulus of one returns 0; a modulus
// of zero or above 2^32 returns 0 with bad_modulus set. The core works on
// one word at a time: the message is first reduced, then each of the 32
// exponent bits takes an issue state, a multiply when the bit is set and a
// square, all on one shared bit-serial modular multiplier. After the last
// exponent bit a closing issue state moves to the done state, from which
// the result is handed to the output register once that register is free.
// Words with an unusable or unit modulus go straight from idle to the done
// state. A finished word sits in the output register, so the next word is
// accepted while it waits to be taken; the core only holds back its own
// next result.
module modular_exponentiation_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mexp_pkg::CFG_W-1:0]        cfg_wdata_i,
  // input word channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mexp_pkg::MSG_W-1:0]        message_word_i,
  // result word channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mexp_pkg::RES_W-1:0]        power_result_o,
  output logic                              bad_modulus_o
);

  logic [mexp_pkg::EXP_W-1:0] exponent_q;
  logic [mexp_pkg::MOD_W-1:0] modulus_q;

  logic                       out_valid_q;
  logic [mexp_pkg::RES_W-1:0] power_result_q;
  logic                       bad_modulus_q;

  mexp_pkg::dp_cmd_t          cmd;
  mexp_pkg::dp_stat_t         stat;
  logic [mexp_pkg::RES_W-1:0] acc;
  logic                       idle;
  logic                       finish;
  logic                       res_zero;
  logic                       res_bad;
  logic                       in_fire;
  logic                       out_free;
  logic                       mod_bad;
  logic                       mod_one;

  // Configuration registers. Only two indexes exist, so every write hits one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= mexp_pkg::EXP_RESET;
      modulus_q  <= mexp_pkg::MOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mexp_pkg::CFG_IDX_EXPONENT: exponent_q <= cfg_wdata_i[mexp_pkg::EXP_W-1:0];
        mexp_pkg::CFG_IDX_MODULUS:  modulus_q  <= cfg_wdata_i[mexp_pkg::MOD_W-1:0];
        default: ;
      endcase
    end
  end

  // A modulus above 2^32 would let the squared residue overflow 64 bits,
  // so it is rejected exactly like zero.
  assign mod_bad = (modulus_q == '0) || (modulus_q > mexp_pkg::MOD_LIMIT);
  assign mod_one = (modulus_q == mexp_pkg::MOD_W'(1));

  assign in_fire    = in_valid_i && idle;
  assign in_stall_o = !idle;
  assign out_free   = !out_valid_q || !out_stall_i;

  mexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .mod_bad_i  (mod_bad),
    .mod_one_i  (mod_one),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idle_o     (idle),
    .finish_o   (finish),
    .res_zero_o (res_zero),
    .res_bad_o  (res_bad)
  );

  mexp_dp u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .message_word_i (message_word_i),
    .exponent_i     (exponent_q),
    .modulus_i      (modulus_q),
    .stat_o         (stat),
    .acc_o          (acc)
  );

  // Output register: loaded when the controller finishes a word, cleared
  // when the downstream side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      power_result_q <= res_zero ? '0 : acc;
      bad_modulus_q  <= res_bad;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign power_result_o = power_result_q;
  assign bad_modulus_o  = bad_modulus_q;

endmodule

/* rtl/mexp_checker.sv */
// Port-level checker for the modular exponentiation core, bound to the top.
// Depends on mexp_pkg for widths.
module mexp_port_checks (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [mexp_pkg::RES_W-1:0]     power_result_o,
  input logic                           bad_modulus_o
);

  // A flagged modulus never carries a nonzero result.
  a_bad_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_modulus_o |-> power_result_o == '0)
    else $error("bad_modulus word with nonzero result");

  // The core works on one word at a time: it stalls right after accepting.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a word is in progress");

  // A new result only appears while a word was in progress.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result produced without a word in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(power_result_o)
      && $stable(bad_modulus_o))
    else $error("stalled result changed");

endmodule

bind modular_exponentiation_core mexp_port_checks u_mexp_port_checks (.*);

/* bench/mexp_checker.sv */
// Checker for the modular exponentiation core: watches the configuration port
// and both word channels, predicts every result word and compares it.
// Depends on mexp_pkg for widths, register indexes and reset values.
module mexp_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mexp_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [mexp_pkg::MSG_W-1:0]     message_word_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [mexp_pkg::RES_W-1:0]     power_result_i,
  input  logic                           bad_modulus_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o,
  output int                             flagged_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [mexp_pkg::RES_W-1:0] power;
    logic                       bad;
  } power_word_t;

  power_word_t                expected_powers[$];
  logic [mexp_pkg::EXP_W-1:0] exponent_copy;
  logic [mexp_pkg::MOD_W-1:0] modulus_copy;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    flagged_o    = 0;
  end

  // Right-to-left square and multiply. Residues stay below 2^32, so every
  // product fits in 64 bits.
  function automatic power_word_t predict_power(
    input logic [mexp_pkg::MSG_W-1:0] word,
    input logic [mexp_pkg::EXP_W-1:0] ex,
    input logic [mexp_pkg::MOD_W-1:0] m
  );
    power_word_t r;
    logic [63:0] m64;
    logic [63:0] base;
    logic [63:0] acc;
    r.power = '0;
    r.bad   = 1'b0;
    m64     = 64'(m);
    if (m == '0 || m > mexp_pkg::MOD_LIMIT) begin
      r.bad = 1'b1;
    end else if (m64 != 64'd1) begin
      base = word % m64;
      acc  = 64'd1;
      for (int i = 0; i < mexp_pkg::EXP_USED; i++) begin
        if (ex[i]) begin
          acc = (acc * base) % m64;
        end
        base = (base * base) % m64;
      end
      r.power = acc[mexp_pkg::RES_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    power_word_t want;
    if (!rst_ni) begin
      exponent_copy = mexp_pkg::EXP_RESET;
      modulus_copy  = mexp_pkg::MOD_RESET;
    end else begin
      // A word accepted at this edge sees the registers as they were before it.
      if (in_valid_i && !in_stall_i) begin
        expected_powers.push_back(predict_power(message_word_i, exponent_copy,
                                                modulus_copy));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_powers.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("checker: unexpected result word power=%h bad=%b",
                     power_result_i, bad_modulus_i);
          end
          fail_count_o++;
        end else begin
          want = expected_powers.pop_front();
          checked_o++;
          if (bad_modulus_i) begin
            flagged_o++;
          end
          if (power_result_i !== want.power || bad_modulus_i !== want.bad) begin
            if (fail_count_o < 10) begin
              $display("checker: result %0d expected power=%h bad=%b, got power=%h bad=%b",
                       checked_o, want.power, want.bad, power_result_i, bad_modulus_i);
            end
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == mexp_pkg::CFG_IDX_EXPONENT) begin
          exponent_copy = cfg_wdata_i[mexp_pkg::EXP_W-1:0];
        end else if (cfg_index_i == mexp_pkg::CFG_IDX_MODULUS) begin
          modulus_copy = cfg_wdata_i[mexp_pkg::MOD_W-1:0];
        end
      end
    end
    pending_o <= expected_powers.size();
  end

endmodule

/* bench/modular_exponentiation_core_tb.sv */
// Testbench top for the modular exponentiation core: clock, reset, register
// writes and message word stimulus, plus the verdict. Depends on mexp_pkg,
// mexp_checker and the core itself.
module modular_exponentiation_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Slowest correct run: about 300 words, each with the longest work, the
  // longest result stall and the longest sender gap. The limit leaves about
  // four times that.
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned TARGET_WORDS  = 270;
  // The tail outlasts the longest word, so it catches any stray result.
  localparam int unsigned TAIL_CYCLES   = 2500;
  localparam logic [mexp_pkg::MOD_W-1:0] MOD_MAX_REG = '1;

  // Every input of the core starts at a known value.
  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           cfg_we_i       = 1'b0;
  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index_i    = mexp_pkg::CFG_IDX_EXPONENT;
  logic [mexp_pkg::CFG_W-1:0]     cfg_wdata_i    = '0;
  logic                           in_valid_i     = 1'b0;
  logic [mexp_pkg::MSG_W-1:0]     message_word_i = '0;
  logic                           out_stall_i    = 1'b0;
  logic                           in_stall_o;
  logic                           out_valid_o;
  logic [mexp_pkg::RES_W-1:0]     power_result_o;
  logic                           bad_modulus_o;

  int fail_count;
  int pending;
  int checked;
  int flagged;
  int words_sent    = 0;
  int settings_used = 0;
  int unsigned cycle_count = 0;

  always #2ns clk_i = ~clk_i;

  modular_exponentiation_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .message_word_i (message_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .power_result_o (power_result_o),
    .bad_modulus_o  (bad_modulus_o)
  );

  // The checker sees exactly what the core sees and hands back its counts.
  mexp_checker power_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .message_word_i (message_word_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .power_result_i (power_result_o),
    .bad_modulus_i  (bad_modulus_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .flagged_o      (flagged)
  );

  // Global watchdog: a hung core or a lost result word ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side back-pressure. It mixes long stretches with no stall, bursts
  // of random single-cycle stalls and a few long stalls, so that stalls land
  // on every phase of the core's work, including while a result is held.
  initial begin : result_stall
    int unsigned pick;
    int unsigned len;
    forever begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(50, 1500);
        repeat (len) @(posedge clk_i);
      end else if (pick < 8) begin
        len = $urandom_range(5, 200);
        repeat (len) begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
          @(posedge clk_i);
        end
      end else begin
        out_stall_i <= 1'b1;
        len = $urandom_range(20, 80);
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // Sender gap before a word: mostly none, often short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // Present one word and hold it, unchanged, until the core takes it. Valid
  // stays high afterwards so that a back-to-back word needs no second
  // assignment of valid in the same time step.
  task automatic send_word(input logic [mexp_pkg::MSG_W-1:0] word,
                           input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    message_word_i <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Stop sending and wait until every expected result word has been taken.
  // The count from the checker is registered, so it is let update before it is read.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Registers change only while the core is idle. Both are written each time;
  // the upper data bit of an exponent write is random, since it is dropped.
  task automatic configure(input logic [mexp_pkg::EXP_W-1:0] ex,
                           input logic [mexp_pkg::MOD_W-1:0] m);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= mexp_pkg::CFG_IDX_EXPONENT;
    cfg_wdata_i <= {1'($urandom_range(0, 1)), ex};
    @(posedge clk_i);
    cfg_index_i <= mexp_pkg::CFG_IDX_MODULUS;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [mexp_pkg::EXP_W-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return mexp_pkg::EXP_W'(1);
      2:       return mexp_pkg::EXP_W'(2);
      3:       return '1;
      4:       return mexp_pkg::EXP_RESET;
      5:       return mexp_pkg::EXP_W'(1) << $urandom_range(0, mexp_pkg::EXP_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // Mostly moduli that exercise the full power loop; the rest covers the
  // unit, zero, exactly 2^32 and oversized cases.
  function automatic logic [mexp_pkg::MOD_W-1:0] pick_modulus();
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4, 5: return {1'b0, 32'($urandom)};
      6, 7:             return mexp_pkg::MOD_W'($urandom_range(2, 50));
      8:                return mexp_pkg::MOD_LIMIT;
      9:                return mexp_pkg::MOD_W'($urandom_range(0, 1));
      default:          return {1'b1, 32'($urandom)};
    endcase
  endfunction

  // Message words: full random 64-bit values keep every bit toggling; the
  // others sit on the edges of the reduction step.
  function automatic logic [mexp_pkg::MSG_W-1:0] pick_word(
    input logic [mexp_pkg::MOD_W-1:0] m
  );
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return {32'($urandom), 32'($urandom)};
      5:             return mexp_pkg::MSG_W'($urandom_range(0, 20));
      6:             return mexp_pkg::MSG_W'(m) * mexp_pkg::MSG_W'($urandom_range(0, 1000));
      7:             return mexp_pkg::MSG_W'(m) + mexp_pkg::MSG_W'($urandom_range(0, 2))
                            - mexp_pkg::MSG_W'(1);
      8:             return '1;
      default:       return mexp_pkg::MSG_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [mexp_pkg::MOD_W-1:0] m;
    int unsigned                n_words;
    bit                         no_gaps;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: exponent 65537 with a unit modulus gives zero, no flag.
    send_word('0, 0);
    send_word('1, 2);
    send_word({32'($urandom), 32'($urandom)}, 0);

    // Zero modulus is flagged.
    configure('1, '0);
    send_word({32'($urandom), 32'($urandom)}, 0);

    // Modulus exactly 2^32, the largest one accepted, with a small exponent.
    configure(mexp_pkg::EXP_W'(3), mexp_pkg::MOD_LIMIT);
    send_word('0, 0);
    send_word('1, 0);
    send_word(mexp_pkg::MSG_W'(mexp_pkg::MOD_LIMIT), 1);
    send_word(mexp_pkg::MSG_W'(mexp_pkg::MOD_LIMIT) - mexp_pkg::MSG_W'(1), 0);
    send_word(mexp_pkg::MSG_W'(mexp_pkg::MOD_LIMIT) + mexp_pkg::MSG_W'(2), 0);

    // Exponent zero gives one for a modulus of at least two, zero base too.
    configure('0, mexp_pkg::MOD_W'(2));
    send_word(mexp_pkg::MSG_W'(5), 0);
    send_word('0, 0);

    // Exponent zero with a unit modulus still gives zero.
    configure('0, mexp_pkg::MOD_W'(1));
    send_word(mexp_pkg::MSG_W'(7), 0);

    // Exponent one just reduces the word.
    configure(mexp_pkg::EXP_W'(1), {1'b0, 32'hFFFF_FFFF});
    send_word('1, 0);
    send_word(mexp_pkg::MSG_W'(32'hFFFF_FFFF), 0);
    send_word(mexp_pkg::MSG_W'(123456789), 3);

    // Moduli above 2^32 are treated as unusable.
    configure(mexp_pkg::EXP_RESET, mexp_pkg::MOD_LIMIT + mexp_pkg::MOD_W'(1));
    send_word(mexp_pkg::MSG_W'(3), 0);
    configure(mexp_pkg::EXP_W'(2), MOD_MAX_REG);
    send_word(mexp_pkg::MSG_W'(9), 0);

    // Full exponent against a large odd modulus.
    configure('1, {1'b0, 32'hFFFF_FFFB});
    send_word({32'($urandom), 32'($urandom)}, 0);
    send_word({32'($urandom), 32'($urandom)}, 0);

    // Random part: a fresh register setting every few words. Some settings
    // run with no sender gaps at all.
    while (words_sent < TARGET_WORDS) begin
      m = pick_modulus();
      configure(pick_exponent(), m);
      n_words = $urandom_range(4, 20);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (n_words) begin
        send_word(pick_word(m), no_gaps ? 0 : pick_gap());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("tb: %0d words sent under %0d register settings, %0d results checked",
             words_sent, settings_used, checked);
    $display("tb: %0d results carried the bad modulus flag", flagged);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mexp_pkg.sv
rtl/mexp_dp.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation_core.sv
rtl/mexp_checker.sv
bench/mexp_checker.sv
bench/modular_exponentiation_core_tb.sv
